### sv/nau_pkg.sv
package nau_pkg;

  localparam int FRAC_BITS      = 11;
  localparam int TABLE_SEGMENTS = 64;
  localparam int SIG_RANGE      = 8;

  localparam int DATA_W  = 16;
  localparam int SLOPE_W = 15;
  localparam int MAG_W   = DATA_W + 1;
  localparam int ARG_W   = MAG_W + 1;
  localparam int KNOT_W  = 32;
  localparam int LK_W    = SLOPE_W + MAG_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int WIDE_W  = SQ_W - FRAC_BITS + 2;

  // table index and position inside one segment
  localparam int SEG_BITS = $clog2(TABLE_SEGMENTS);
  localparam int IDX_W    = SEG_BITS + 1;
  localparam int FR_BITS  = FRAC_BITS + $clog2(SIG_RANGE) - SEG_BITS;
  localparam int SIG_SPAN = SIG_RANGE << FRAC_BITS;

  localparam int ONE_Q      = 1 << FRAC_BITS;
  localparam int Q31_RND    = 1 << (30 - FRAC_BITS);
  localparam int Q31_SHIFT  = 31 - FRAC_BITS;
  localparam int LK_HALF    = 1 << (SLOPE_W - 1);
  localparam int SQ_HALF    = 1 << (FRAC_BITS - 1);
  localparam int SLOPE_RND  = 1 << (SLOPE_W - 1 - FRAC_BITS);
  localparam int SLOPE_SHR  = SLOPE_W - FRAC_BITS;

  localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(328);
  localparam logic [KNOT_W-1:0]  Q31_ONE     = {1'b1, {(KNOT_W-1){1'b0}}};

  // knot spacing in Q.31
  localparam logic [63:0] KNOT_STEP = (64'(SIG_RANGE) << 31) / 64'(TABLE_SEGMENTS);

  typedef enum logic [2:0] {
    CMD_RELU      = 3'd0,
    CMD_LEAKY     = 3'd1,
    CMD_SIGMOID   = 3'd2,
    CMD_TANH      = 3'd3,
    CMD_RELU_D    = 3'd4,
    CMD_LEAKY_D   = 3'd5,
    CMD_SIGMOID_D = 3'd6,
    CMD_TANH_D    = 3'd7
  } cmd_t;

  typedef logic [KNOT_W-1:0] knot_tab_t [0:TABLE_SEGMENTS];

  // restoring shift-and-subtract divide, only used while building the knots
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid knots in Q0.31: knot k = 2^62 / (2^31 + 2^31*e^(-k*step)), with e^step
  // taken from a Taylor series. Evaluated at elaboration only.
  function automatic knot_tab_t build_knots();
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] d;
    logic [63:0] p;
    knot_tab_t   tab;
    e    = 64'd1 << 31;
    term = 64'd1 << 31;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * KNOT_STEP) >> 31, 64'(n));
      e    = e + term;
    end
    d = udiv64(64'd1 << 62, e);
    p = 64'd1 << 31;
    for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
      tab[k] = KNOT_W'(udiv64(64'd1 << 62, (64'd1 << 31) + p));
      p      = (p * d) >> 31;
    end
    return tab;
  endfunction

  localparam knot_tab_t KNOTS = build_knots();

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] x;
    logic                     neg;
    logic [MAG_W-1:0]         mag;
    logic [KNOT_W-1:0]        k0;
    logic [KNOT_W-1:0]        diff;
    logic [FR_BITS-1:0]       fr;
  } s1_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] x;
    logic                     neg;
    logic [KNOT_W-1:0]        sig;
    logic [LK_W-1:0]          lk;
    logic [SQ_W-1:0]          sq;
  } s2_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic                     neg;
    logic [KNOT_W-1:0]        sv;
    logic signed [DATA_W-1:0] ys;
  } s3_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic                     neg;
    logic [KNOT_W-1:0]        pv;
    logic signed [DATA_W-1:0] ys;
  } s4_t;

endpackage

### sv/nau_front.sv
module nau_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [2:0]                        in_cmd,
  input  logic signed [nau_pkg::DATA_W-1:0] in_x,
  output logic                              s1_vld_r,
  output nau_pkg::s1_t                      s1_r
);

  nau_pkg::s1_t                    s1_nxt;
  nau_pkg::cmd_t                   cmd;
  logic                            neg;
  logic [nau_pkg::MAG_W-1:0]       xe;
  logic [nau_pkg::MAG_W-1:0]       mag;
  logic [nau_pkg::ARG_W-1:0]       arg;
  logic                            sat;
  logic [nau_pkg::IDX_W-1:0]       idx_lo;
  logic [nau_pkg::IDX_W-1:0]       idx_hi;
  logic [nau_pkg::KNOT_W-1:0]      k_lo;
  logic [nau_pkg::KNOT_W-1:0]      k_hi;

  always_comb begin
    cmd = nau_pkg::cmd_t'(in_cmd);
    neg = in_x[nau_pkg::DATA_W-1];
    xe  = {in_x[nau_pkg::DATA_W-1], in_x};
    mag = neg ? (~xe + 1'b1) : xe;
    // tanh(x) = 2*s(2x) - 1
    arg = (cmd == nau_pkg::CMD_TANH) ? {mag, 1'b0} : {1'b0, mag};
    sat = arg >= nau_pkg::ARG_W'(nau_pkg::SIG_SPAN);
    idx_lo = {1'b0, arg[nau_pkg::FR_BITS +: nau_pkg::SEG_BITS]};
    idx_hi = idx_lo + 1'b1;
    k_lo   = nau_pkg::KNOTS[idx_lo];
    k_hi   = nau_pkg::KNOTS[idx_hi];

    s1_nxt.cmd  = cmd;
    s1_nxt.x    = in_x;
    s1_nxt.neg  = neg;
    s1_nxt.mag  = mag;
    s1_nxt.k0   = sat ? nau_pkg::KNOTS[nau_pkg::TABLE_SEGMENTS] : k_lo;
    s1_nxt.diff = sat ? '0 : (k_hi - k_lo);
    s1_nxt.fr   = sat ? '0 : arg[nau_pkg::FR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

### sv/nau_interp.sv
module nau_interp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [nau_pkg::SLOPE_W-1:0] slope,
  input  logic                        s1_vld,
  input  nau_pkg::s1_t                s1,
  output logic                        s2_vld_r,
  output nau_pkg::s2_t                s2_r
);

  nau_pkg::s2_t                                     s2_nxt;
  logic [nau_pkg::KNOT_W+nau_pkg::FR_BITS-1:0]      step_prod;

  always_comb begin
    step_prod   = s1.diff * {{nau_pkg::KNOT_W{1'b0}}, s1.fr};
    s2_nxt.cmd  = s1.cmd;
    s2_nxt.x    = s1.x;
    s2_nxt.neg  = s1.neg;
    s2_nxt.sig  = s1.k0 + nau_pkg::KNOT_W'(step_prod >> nau_pkg::FR_BITS);
    s2_nxt.lk   = nau_pkg::LK_W'(slope) * nau_pkg::LK_W'(s1.mag);
    s2_nxt.sq   = nau_pkg::SQ_W'(s1.mag) * nau_pkg::SQ_W'(s1.mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

### sv/nau_shape.sv
module nau_shape (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [nau_pkg::SLOPE_W-1:0] slope,
  input  logic                        s2_vld,
  input  nau_pkg::s2_t                s2,
  output logic                        s3_vld_r,
  output nau_pkg::s3_t                s3_r
);

  localparam logic signed [nau_pkg::WIDE_W-1:0] Y_MAX =
    nau_pkg::WIDE_W'((2 ** (nau_pkg::DATA_W - 1)) - 1);
  localparam logic signed [nau_pkg::WIDE_W-1:0] Y_MIN =
    nau_pkg::WIDE_W'(-(2 ** (nau_pkg::DATA_W - 1)));

  nau_pkg::s3_t                        s3_nxt;
  logic [nau_pkg::KNOT_W-1:0]          sig_ref;
  logic [nau_pkg::KNOT_W:0]            tanh_v;
  logic                                pos;
  logic [nau_pkg::LK_W:0]              lk_m;
  logic [nau_pkg::SQ_W:0]              sq_m;
  logic [nau_pkg::SLOPE_W:0]           slope_q;
  logic signed [nau_pkg::WIDE_W-1:0]   one_w;
  logic signed [nau_pkg::WIDE_W-1:0]   wide;

  always_comb begin
    sig_ref = s2.neg ? (nau_pkg::Q31_ONE - s2.sig) : s2.sig;
    tanh_v  = {s2.sig, 1'b0} - {1'b0, nau_pkg::Q31_ONE};
    pos     = !s2.neg && (s2.x != '0);
    lk_m    = ({1'b0, s2.lk} + (nau_pkg::LK_W+1)'(nau_pkg::LK_HALF)) >> nau_pkg::SLOPE_W;
    sq_m    = ({1'b0, s2.sq} + (nau_pkg::SQ_W+1)'(nau_pkg::SQ_HALF)) >> nau_pkg::FRAC_BITS;
    slope_q = ({1'b0, slope} + (nau_pkg::SLOPE_W+1)'(nau_pkg::SLOPE_RND))
              >> nau_pkg::SLOPE_SHR;
    one_w   = nau_pkg::WIDE_W'(nau_pkg::ONE_Q);

    s3_nxt.cmd = s2.cmd;
    s3_nxt.neg = s2.neg;

    case (s2.cmd)
      nau_pkg::CMD_SIGMOID:   s3_nxt.sv = sig_ref;
      nau_pkg::CMD_SIGMOID_D: s3_nxt.sv = sig_ref;
      nau_pkg::CMD_TANH:      s3_nxt.sv = tanh_v[nau_pkg::KNOT_W-1:0];
      default:                s3_nxt.sv = '0;
    endcase

    case (s2.cmd)
      nau_pkg::CMD_RELU: begin
        wide = pos ? nau_pkg::WIDE_W'(s2.x) : '0;
      end
      nau_pkg::CMD_LEAKY: begin
        wide = pos ? nau_pkg::WIDE_W'(s2.x) : -nau_pkg::WIDE_W'(lk_m);
      end
      nau_pkg::CMD_RELU_D: begin
        wide = pos ? one_w : '0;
      end
      nau_pkg::CMD_LEAKY_D: begin
        wide = pos ? one_w : nau_pkg::WIDE_W'(slope_q);
      end
      nau_pkg::CMD_TANH_D: begin
        // operand is the tanh output itself: 1 - y*y
        wide = one_w - nau_pkg::WIDE_W'(sq_m);
      end
      default: begin
        wide = '0;
      end
    endcase

    if (wide > Y_MAX) begin
      s3_nxt.ys = nau_pkg::DATA_W'(Y_MAX);
    end else if (wide < Y_MIN) begin
      s3_nxt.ys = nau_pkg::DATA_W'(Y_MIN);
    end else begin
      s3_nxt.ys = nau_pkg::DATA_W'(wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

### sv/nau_final.sv
module nau_final (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s3_vld,
  input  nau_pkg::s3_t                      s3,
  output logic                              out_valid_r,
  output logic signed [nau_pkg::DATA_W-1:0] out_result_y_r
);

  nau_pkg::s4_t                           s4_nxt;
  nau_pkg::s4_t                           s4_r;
  logic                                   s4_vld_r;
  logic [nau_pkg::KNOT_W-1:0]             comp;
  logic [2*nau_pkg::KNOT_W-1:0]           prod;
  logic [nau_pkg::KNOT_W:0]               rnd;
  logic [nau_pkg::DATA_W-1:0]             q;
  logic signed [nau_pkg::DATA_W-1:0]      out_result_y_nxt;

  // s * (1 - s) for the sigmoid derivative
  always_comb begin
    comp       = nau_pkg::Q31_ONE - s3.sv;
    prod       = s3.sv * {{nau_pkg::KNOT_W{1'b0}}, comp};
    s4_nxt.cmd = s3.cmd;
    s4_nxt.neg = s3.neg;
    s4_nxt.ys  = s3.ys;
    s4_nxt.pv  = (s3.cmd == nau_pkg::CMD_SIGMOID_D) ?
                 nau_pkg::KNOT_W'(prod >> 31) : s3.sv;
  end

  // Q0.31 -> Q4.FRAC_BITS, round half up (value is non-negative)
  always_comb begin
    rnd = ({1'b0, s4_r.pv} + (nau_pkg::KNOT_W+1)'(nau_pkg::Q31_RND)) >> nau_pkg::Q31_SHIFT;
    q   = rnd[nau_pkg::DATA_W-1:0];
    case (s4_r.cmd)
      nau_pkg::CMD_SIGMOID:   out_result_y_nxt = q;
      nau_pkg::CMD_SIGMOID_D: out_result_y_nxt = q;
      nau_pkg::CMD_TANH:      out_result_y_nxt = s4_r.neg ? -q : q;
      default:                out_result_y_nxt = s4_r.ys;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s4_vld_r    <= s3_vld;
      out_valid_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_vld) begin
      s4_r <= s4_nxt;
    end
    if (s4_vld_r) begin
      out_result_y_r <= out_result_y_nxt;
    end
  end

  a_pv_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r && (s4_r.cmd == nau_pkg::CMD_SIGMOID || s4_r.cmd == nau_pkg::CMD_TANH ||
                 s4_r.cmd == nau_pkg::CMD_SIGMOID_D) |-> s4_r.pv <= nau_pkg::Q31_ONE)
    else $error("table value above one");

  a_sig_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r && (s4_r.cmd == nau_pkg::CMD_SIGMOID || s4_r.cmd == nau_pkg::CMD_SIGMOID_D)
    |=> !out_result_y_r[nau_pkg::DATA_W-1])
    else $error("negative sigmoid result");

  a_tanh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r && s4_r.cmd == nau_pkg::CMD_TANH |=>
    (out_result_y_r <= $signed(nau_pkg::DATA_W'(nau_pkg::ONE_Q))) &&
    (out_result_y_r >= -$signed(nau_pkg::DATA_W'(nau_pkg::ONE_Q))))
    else $error("tanh result outside [-1, 1]");

endmodule

### sv/neural_activation_unit.sv
// Channel   Transfer condition      Signals
// input     start && !busy          in_cmd, in_operand_x
// result    out_valid (one cycle)   out_result_y
// config    cfg_we                  cfg_wdata (leaky slope, Q0.15)
//
// Five register stages: table lookup, interpolation/products, shaping and
// saturation, sigmoid-derivative multiply, rounding into the output register.
// One sample per clock while busy is low; the result leaves through the output register.
// busy is high only while rst_n is low and the cycle after; there is no
// table clearing. Results cannot be held off, so the pipeline never stalls.
module neural_activation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_cmd,
  input  logic signed [nau_pkg::DATA_W-1:0] in_operand_x,
  output logic                              out_valid,
  output logic signed [nau_pkg::DATA_W-1:0] out_result_y,
  input  logic                              cfg_we,
  input  logic [nau_pkg::SLOPE_W-1:0]       cfg_wdata
);

  logic                        busy_r;
  logic [nau_pkg::SLOPE_W-1:0] slope_r;
  logic                        in_vld;
  logic                        s1_vld;
  logic                        s2_vld;
  logic                        s3_vld;
  nau_pkg::s1_t                s1;
  nau_pkg::s2_t                s2;
  nau_pkg::s3_t                s3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      slope_r <= nau_pkg::SLOPE_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        slope_r <= cfg_wdata;
      end
    end
  end

  assign busy   = busy_r;
  assign in_vld = start && !busy_r;

  nau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_cmd   (in_cmd),
    .in_x     (in_operand_x),
    .s1_vld_r (s1_vld),
    .s1_r     (s1)
  );

  nau_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .slope    (slope_r),
    .s1_vld   (s1_vld),
    .s1       (s1),
    .s2_vld_r (s2_vld),
    .s2_r     (s2)
  );

  nau_shape u_shape (
    .clk      (clk),
    .rst_n    (rst_n),
    .slope    (slope_r),
    .s2_vld   (s2_vld),
    .s2       (s2),
    .s3_vld_r (s3_vld),
    .s3_r     (s3)
  );

  nau_final u_final (
    .clk            (clk),
    .rst_n          (rst_n),
    .s3_vld         (s3_vld),
    .s3             (s3),
    .out_valid_r    (out_valid),
    .out_result_y_r (out_result_y)
  );

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##5 out_valid)
    else $error("accepted sample produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without matching transfer");

endmodule
